>>> rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared codes and types of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int OW = 4;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_PROBE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_BAD_ORD  = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  typedef struct packed {
    logic [OW-1:0] order;
    logic          head;
    logic          busy;
  } unit_meta_t;

endpackage

`default_nettype wire

>>> rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over 2^(active order limit) units with one fifo free list
// per order; allocate, free with buddy merge, and probe
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   func_i, req_order_i, free_address_i
//  out      output     out_valid_o / out_stall_i status_o, block_address_o, can_allocate_o
//  cfg      input      cfg_we_i                  cfg_wdata_i
//
//  one beat at a time: allocate scans the orders and then splits, probe
//  only scans, and free merges level by level until a buddy check ends the
//  merge; a bad order or an invalid free ends the beat with no list change,
//  and the next beat is taken once the FSM is back in idle
//  the unit metadata memory, with one read and one write port, sets the pace of splits and merges
//  after reset and after every cfg write a clear pass over all 2^MAX_ORDER
//  units runs on the metadata memory while in_stall_o is high
//  a finished result waits in the output register while the next beat enters
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator #(
  parameter int MAX_ORDER = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [3:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           func_i,
  input  wire logic [3:0]           req_order_i,
  input  wire logic [MAX_ORDER-1:0] free_address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [MAX_ORDER-1:0]      block_address_o,
  output logic                      can_allocate_o
);

  localparam int AW    = MAX_ORDER;
  localparam int UNITS = 1 << MAX_ORDER;
  localparam int LISTS = MAX_ORDER + 1;
  localparam int LW    = $clog2(LISTS);
  localparam int OW    = bba_pkg::OW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_AUL   = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_SPAPP = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_MCHK  = 4'd9;
  localparam logic [3:0] S_MEVAL = 4'd10;
  localparam logic [3:0] S_MWR   = 4'd11;
  localparam logic [3:0] S_APP   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [OW-1:0] amo_q;
  logic [OW-1:0] cfg_sat;
  logic [AW-1:0] clr_q;
  logic [1:0]    func_q;
  logic [OW-1:0] req_q;
  logic [OW:0]   ord_q, ord_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] bud_q, bud_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic          res_can_q, res_can_d;
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [AW-1:0] block_addr_q;
  logic          can_q;

  logic [AW-1:0]    first_q [LISTS];
  logic [AW-1:0]    last_q  [LISTS];
  logic [LISTS-1:0] ne_q;
  logic [LW-1:0]    lidx;

  bba_pkg::unit_meta_t um_mem [UNITS];
  logic [AW-1:0]       nx_mem [UNITS];
  logic [AW-1:0]       pv_mem [UNITS];
  bba_pkg::unit_meta_t um_rd_q, um_wd;
  logic [AW-1:0]       nx_rd_q, pv_rd_q;
  logic [AW-1:0]       rd_addr, um_wa, nx_wa, nx_wd, pv_wa, pv_wd;
  logic                um_we, nx_we, pv_we;

  logic          app_en, ul_en;
  logic [AW-1:0] app_n, ul_n;
  logic          ul_first, ul_last;
  logic [AW-1:0] bit_o, lo_a, hi_a;
  logic          in_acc;

  assign lidx     = ord_q[LW-1:0];
  assign cfg_sat  = (cfg_wdata_i > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : cfg_wdata_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign ul_first = (first_q[lidx] == ul_n);
  assign ul_last  = (last_q[lidx] == ul_n);
  assign bit_o    = AW'(1) << ord_q[OW-1:0];
  assign lo_a     = (addr_q < bud_q) ? addr_q : bud_q;
  assign hi_a     = (addr_q < bud_q) ? bud_q : addr_q;

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign block_address_o = block_addr_q;
  assign can_allocate_o  = can_q;

  always_comb begin
    state_d    = state_q;
    ord_d      = ord_q;
    addr_d     = addr_q;
    bud_d      = bud_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    res_can_d  = res_can_q;
    rd_addr    = addr_q;
    um_we      = 1'b0;
    um_wa      = addr_q;
    um_wd      = '0;
    app_en     = 1'b0;
    app_n      = addr_q;
    ul_en      = 1'b0;
    ul_n       = addr_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_st_d   = bba_pkg::ST_OK;
          res_addr_d = '0;
          res_can_d  = 1'b0;
          ord_d      = {1'b0, req_order_i};
          addr_d     = free_address_i;
          state_d    = S_DONE;
          case (func_i)
            bba_pkg::FUNC_ALLOC, bba_pkg::FUNC_PROBE: begin
              if (req_order_i > amo_q) begin
                res_st_d = bba_pkg::ST_BAD_ORD;
              end else begin
                state_d = S_SCAN;
              end
            end
            bba_pkg::FUNC_FREE: begin
              if ((free_address_i >> amo_q) != '0) begin
                res_st_d = bba_pkg::ST_BAD_FREE;
              end else begin
                state_d = S_FRD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        um_we = 1'b1;
        um_wa = clr_q;
        if (clr_q == '0) begin
          um_wd = '{order: amo_q, head: 1'b1, busy: 1'b0};
        end
        if (clr_q == {AW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ord_q > {1'b0, amo_q}) begin
          if (func_q == bba_pkg::FUNC_ALLOC) begin
            res_st_d = bba_pkg::ST_NO_BLOCK;
          end
          state_d = S_DONE;
        end else if (ne_q[lidx]) begin
          if (func_q == bba_pkg::FUNC_PROBE) begin
            res_can_d = 1'b1;
            state_d   = S_DONE;
          end else begin
            addr_d  = first_q[lidx];
            state_d = S_ARD;
          end
        end else begin
          ord_d = ord_q + 1'b1;
        end
      end
      S_ARD: begin
        state_d = S_AUL;
      end
      S_AUL: begin
        ul_en   = 1'b1;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (ord_q > {1'b0, req_q}) begin
          ord_d   = ord_q - 1'b1;
          state_d = S_SPAPP;
        end else begin
          um_we      = 1'b1;
          um_wd      = '{order: req_q, head: 1'b1, busy: 1'b1};
          res_addr_d = addr_q;
          state_d    = S_DONE;
        end
      end
      S_SPAPP: begin
        um_we   = 1'b1;
        um_wa   = addr_q | bit_o;
        um_wd   = '{order: ord_q[OW-1:0], head: 1'b1, busy: 1'b0};
        app_en  = 1'b1;
        app_n   = addr_q | bit_o;
        state_d = S_SPLIT;
      end
      S_FRD: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (!um_rd_q.head || !um_rd_q.busy) begin
          res_st_d = bba_pkg::ST_BAD_FREE;
          state_d  = S_DONE;
        end else begin
          um_we   = 1'b1;
          um_wd   = '{order: um_rd_q.order, head: 1'b1, busy: 1'b0};
          ord_d   = (um_rd_q.order > amo_q) ? {1'b0, amo_q} : {1'b0, um_rd_q.order};
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (ord_q >= {1'b0, amo_q}) begin
          state_d = S_APP;
        end else begin
          bud_d   = addr_q ^ bit_o;
          rd_addr = addr_q ^ bit_o;
          state_d = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (!um_rd_q.head || um_rd_q.busy || ({1'b0, um_rd_q.order} != ord_q)) begin
          state_d = S_APP;
        end else begin
          ul_en   = 1'b1;
          ul_n    = bud_q;
          um_we   = 1'b1;
          um_wa   = hi_a;
          um_wd   = '0;
          addr_d  = lo_a;
          ord_d   = ord_q + 1'b1;
          state_d = S_MWR;
        end
      end
      S_MWR: begin
        um_we   = 1'b1;
        um_wd   = '{order: ord_q[OW-1:0], head: 1'b1, busy: 1'b0};
        state_d = S_MCHK;
      end
      S_APP: begin
        app_en  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // link writes for append and for unlink of a middle entry
  always_comb begin
    nx_we = 1'b0;
    nx_wa = last_q[lidx];
    nx_wd = app_n;
    pv_we = 1'b0;
    pv_wa = app_n;
    pv_wd = last_q[lidx];
    if (app_en && ne_q[lidx]) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (ul_en && !ul_first && !ul_last) begin
      nx_we = 1'b1;
      nx_wa = pv_rd_q;
      nx_wd = nx_rd_q;
      pv_we = 1'b1;
      pv_wa = nx_rd_q;
      pv_wd = pv_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (um_we) begin
      um_mem[um_wa] <= um_wd;
    end
    um_rd_q <= um_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    nx_rd_q <= nx_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    pv_rd_q <= pv_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= LISTS'(1) << MAX_ORDER;
      for (int i = 0; i < LISTS; i++) begin
        first_q[i] <= '0;
        last_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      ne_q <= LISTS'(1) << cfg_sat;
      for (int i = 0; i < LISTS; i++) begin
        first_q[i] <= '0;
        last_q[i]  <= '0;
      end
    end else if (app_en) begin
      if (!ne_q[lidx]) begin
        first_q[lidx] <= app_n;
        last_q[lidx]  <= app_n;
        ne_q[lidx]    <= 1'b1;
      end else begin
        last_q[lidx] <= app_n;
      end
    end else if (ul_en) begin
      if (ul_first && ul_last) begin
        ne_q[lidx] <= 1'b0;
      end else if (ul_first) begin
        first_q[lidx] <= nx_rd_q;
      end else if (ul_last) begin
        last_q[lidx] <= pv_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      amo_q       <= OW'(MAX_ORDER);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        amo_q   <= cfg_sat;
        clr_q   <= '0;
        state_q <= S_CLR;
      end else begin
        state_q <= state_d;
        if (state_q == S_CLR) begin
          clr_q <= clr_q + 1'b1;
        end
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q      <= ord_d;
    addr_q     <= addr_d;
    bud_q      <= bud_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_can_q  <= res_can_d;
    if (in_acc) begin
      func_q <= func_i;
      req_q  <= req_order_i;
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      status_q     <= res_st_q;
      block_addr_q <= res_addr_q;
      can_q        <= res_can_q;
    end
  end

  a_no_dual_list_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(app_en && ul_en))
    else $error("append and unlink in one cycle");

  a_addr_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_address_o != '0) |-> (status_o == bba_pkg::ST_OK && !can_allocate_o))
    else $error("block address with bad status or probe answer");

  a_can_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && can_allocate_o) |-> (status_o == bba_pkg::ST_OK))
    else $error("probe answer with bad status");

  a_split_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPAPP) |-> (ord_q < {1'b0, amo_q}))
    else $error("split beyond active max order");

endmodule

`default_nettype wire

>>> dv/buddy_block_allocator_test.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// self-checking bench: a directed table then random allocate/free/probe beats,
// every result compared with a behavioral buddy allocator kept in step
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module buddy_block_allocator_test;

  localparam int MO = 10;
  localparam int UN = 1 << MO;
  localparam int WATCH_LIMIT = 40000;

  typedef struct packed {
    logic [1:0]    status;
    logic [MO-1:0] addr;
    logic          can;
  } alloc_res_t;

  typedef struct {
    logic [1:0] func;
    logic [3:0] ord;
    logic [9:0] faddr;
    bit         fixed;
    alloc_res_t res;
  } dir_row_t;

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          cfg_we_i = 0;
  logic [3:0]    cfg_wdata_i = 0;
  logic          in_valid_i = 0;
  logic          in_stall_o;
  logic [1:0]    func_i = 0;
  logic [3:0]    req_order_i = 0;
  logic [MO-1:0] free_address_i = 0;
  logic          out_valid_o;
  logic          out_stall_i = 0;
  logic [1:0]    status_o;
  logic [MO-1:0] block_address_o;
  logic          can_allocate_o;

  always #6 clk_i = ~clk_i;

  buddy_block_allocator #(.MAX_ORDER(MO)) u_dut (.*);

  // allocator state
  int          top_ord;
  logic [3:0]  u_ord [UN];
  bit          u_head [UN];
  bit          u_busy [UN];
  int          nxt [UN];
  int          prv [UN];
  int          l_first [MO+1];
  int          l_last [MO+1];
  bit          l_full [MO+1];
  int          held [$];

  alloc_res_t  pending [$];
  int          mism = 0;
  int          idle_cycles = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  bit          hold_off = 0;

  function automatic void region_init(int o);
    top_ord = o;
    for (int i = 0; i < UN; i++) begin
      u_ord[i] = 0; u_head[i] = 0; u_busy[i] = 0; nxt[i] = 0; prv[i] = 0;
    end
    for (int i = 0; i <= MO; i++) begin
      l_first[i] = 0; l_last[i] = 0; l_full[i] = 0;
    end
    u_ord[0] = 4'(o); u_head[0] = 1; l_full[o] = 1;
    held.delete();
  endfunction

  function automatic void list_push(int o, int n);
    if (!l_full[o]) begin
      l_first[o] = n; l_last[o] = n; l_full[o] = 1;
    end else begin
      nxt[l_last[o]] = n; prv[n] = l_last[o]; l_last[o] = n;
    end
  endfunction

  function automatic void list_drop(int o, int n);
    bit f, l;
    f = l_first[o] == n;
    l = l_last[o] == n;
    if (f && l) l_full[o] = 0;
    else if (f) l_first[o] = nxt[n];
    else if (l) l_last[o] = prv[n];
    else begin
      nxt[prv[n]] = nxt[n]; prv[nxt[n]] = prv[n];
    end
  endfunction

  function automatic alloc_res_t alloc_predict(logic [1:0] f, logic [3:0] req, int fa);
    alloc_res_t r;
    int k, a, o, b, hi;
    r = '0;
    if (f == bba_pkg::FUNC_ALLOC) begin
      if (req > top_ord) r.status = bba_pkg::ST_BAD_ORD;
      else begin
        k = req;
        while (k <= top_ord && !l_full[k]) k++;
        if (k > top_ord) r.status = bba_pkg::ST_NO_BLOCK;
        else begin
          a = l_first[k];
          list_drop(k, a);
          while (k > req) begin
            k--;
            b = (a + (1 << k)) % UN;
            u_ord[b] = 4'(k); u_head[b] = 1; u_busy[b] = 0;
            list_push(k, b);
          end
          u_ord[a] = req; u_head[a] = 1; u_busy[a] = 1;
          r.addr = MO'(a);
          held.push_back(a);
        end
      end
    end else if (f == bba_pkg::FUNC_FREE) begin
      if (fa >= (1 << top_ord) || !u_head[fa] || !u_busy[fa]) r.status = bba_pkg::ST_BAD_FREE;
      else begin
        a = fa;
        o = (u_ord[a] > top_ord) ? top_ord : u_ord[a];
        u_busy[a] = 0;
        foreach (held[i]) if (held[i] == fa) begin
          held.delete(i);
          break;
        end
        while (o < top_ord) begin
          b = (a ^ (1 << o)) % UN;
          if (!u_head[b] || u_busy[b] || u_ord[b] != o) break;
          list_drop(o, b);
          hi = a > b ? a : b;
          a = a < b ? a : b;
          u_head[hi] = 0; u_ord[hi] = 0;
          o++;
          u_ord[a] = 4'(o); u_head[a] = 1;
        end
        list_push(o, a);
      end
    end else if (f == bba_pkg::FUNC_PROBE) begin
      if (req > top_ord) r.status = bba_pkg::ST_BAD_ORD;
      else for (int j = req; j <= top_ord; j++) if (l_full[j]) r.can = 1;
    end
    return r;
  endfunction

  // valid stays high after the last beat; callers drop it before waiting
  task automatic send_beat(logic [1:0] f, logic [3:0] req, logic [9:0] fa,
                           bit fixed, alloc_res_t res);
    alloc_res_t p;
    while (!hold_off && in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; func_i <= f; req_order_i <= req; free_address_i <= fa;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = alloc_predict(f, req, fa);
    if (fixed && p !== res) begin
      mism++;
      if (mism <= 10) $display("table row disagrees: row %h, predicted %h", res, p);
    end
    pending.push_back(p);
  endtask

  task automatic write_top_order(logic [3:0] v);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    region_init(v > MO ? MO : v);
  endtask

  task automatic random_beats(int n, int max_o);
    logic [1:0] f;
    logic [3:0] o;
    logic [9:0] a;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      o = 4'($urandom_range(max_o));
      a = 10'($urandom);
      if (r < 40) f = bba_pkg::FUNC_ALLOC;
      else if (r < 78) begin
        f = bba_pkg::FUNC_FREE;
        if (held.size() != 0 && $urandom_range(9) < 8)
          a = 10'(held[$urandom_range(held.size() - 1)]);
      end else if (r < 92) f = bba_pkg::FUNC_PROBE;
      else begin
        f = 2'($urandom_range(3)); o = 4'($urandom);
      end
      send_beat(f, o, a, 0, '0);
    end
  endtask

  // receiver side
  always @(posedge clk_i) begin
    alloc_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, block_address_o, can_allocate_o};
      if (pending.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          mism++;
          if (mism <= 10)
            $display("status exp %0d got %0d, addr exp %0d got %0d, can exp %0d got %0d",
                     want.status, got.status, want.addr, got.addr, want.can, got.can);
        end
      end
    end
    out_stall_i <= hold_off || (out_stall_pct > 0 && $urandom_range(99) < out_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  dir_row_t dir_tab [20] = '{
    '{bba_pkg::FUNC_PROBE, 4'd10, 10'd0,    1, '{bba_pkg::ST_OK, 10'd0, 1'b1}},
    '{bba_pkg::FUNC_PROBE, 4'd11, 10'd0,    1, '{bba_pkg::ST_BAD_ORD, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_ALLOC, 4'd15, 10'd0,    1, '{bba_pkg::ST_BAD_ORD, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd0,    1, '{bba_pkg::ST_BAD_FREE, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_ALLOC, 4'd0,  10'd0,    1, '{bba_pkg::ST_OK, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_ALLOC, 4'd0,  10'd0,    1, '{bba_pkg::ST_OK, 10'd1, 1'b0}},
    '{bba_pkg::FUNC_ALLOC, 4'd9,  10'd0,    1, '{bba_pkg::ST_OK, 10'd512, 1'b0}},
    '{bba_pkg::FUNC_PROBE, 4'd9,  10'd0,    1, '{bba_pkg::ST_OK, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_ALLOC, 4'd10, 10'd0,    1, '{bba_pkg::ST_NO_BLOCK, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd1023, 1, '{bba_pkg::ST_BAD_FREE, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd3,    0, '0},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd1,    0, '0},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd1,    1, '{bba_pkg::ST_BAD_FREE, 10'd0, 1'b0}},
    '{2'd3,                4'd15, 10'd1023, 1, '{bba_pkg::ST_OK, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd0,    0, '0},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd512,  0, '0},
    '{bba_pkg::FUNC_PROBE, 4'd10, 10'd0,    1, '{bba_pkg::ST_OK, 10'd0, 1'b1}},
    '{bba_pkg::FUNC_ALLOC, 4'd10, 10'd0,    1, '{bba_pkg::ST_OK, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_PROBE, 4'd0,  10'd0,    1, '{bba_pkg::ST_OK, 10'd0, 1'b0}},
    '{bba_pkg::FUNC_FREE,  4'd0,  10'd0,    0, '0}
  };

  initial begin
    region_init(MO);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    foreach (dir_tab[i])
      send_beat(dir_tab[i].func, dir_tab[i].ord, dir_tab[i].faddr,
                dir_tab[i].fixed, dir_tab[i].res);
    random_beats(150, 10);

    // sender keeps offering while the receiver holds off
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      random_beats(10, 10);
    join

    write_top_order(4'd0);
    send_beat(bba_pkg::FUNC_ALLOC, 4'd1, 10'd0, 1, '{bba_pkg::ST_BAD_ORD, 10'd0, 1'b0});
    random_beats(30, 1);
    write_top_order(4'd15);
    in_idle_pct = 49;
    random_beats(150, 10);
    write_top_order(4'd3);
    in_idle_pct = 0; out_stall_pct = 49;
    random_beats(150, 4);
    write_top_order(4'd1);
    random_beats(40, 2);
    write_top_order(4'd6);
    in_idle_pct = 9; out_stall_pct = 9;
    random_beats(150, 7);
    write_top_order(4'd10);
    in_idle_pct = 0; out_stall_pct = 0;
    random_beats(120, 10);

    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mism == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
